FILE: hw/rtl/gca_pkg.sv
// Shared types and constants for the grid cell aggregator.
`default_nettype none
package gca_pkg;
    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int TOT_W      = 48;
    localparam int DIV_STEPS  = TOT_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam logic [2:0] MODE_SUM    = 3'd0;
    localparam logic [2:0] MODE_MEAN   = 3'd1;
    localparam logic [2:0] MODE_MEDIAN = 3'd2;
    localparam logic [2:0] MODE_MAX    = 3'd3;
    localparam logic [2:0] MODE_MIN    = 3'd4;

    localparam logic REG_AGG_MODE  = 1'b0;
    localparam logic REG_UNDEF_PROP = 1'b1;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic               sample_undefined;
        logic               has_sample;
        logic               last_in_cell;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               result_undefined;
    } t_out_word;

    typedef enum logic [2:0] {
        SEL_UNDEF,
        SEL_SUM,
        SEL_EXT,
        SEL_DIV,
        SEL_MED
    } t_sel;

    typedef struct packed {
        logic ready;      // input side may take a word
        logic div_load;
        logic div_step;
        logic med_start;
        logic med_issue;
        logic med_next;
        logic out_load;   // latch result and clear the cell
        t_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic       cell_closed;
        logic       no_result;   // empty cell, propagated undefined or bad mode
        logic [2:0] mode;
        logic       div_last;
        logic       j_last;
        logic       med_hit;
        logic       out_full;
    } t_dp_stat;
endpackage
`default_nettype wire

FILE: hw/rtl/gca_datapath.sv
// Datapath: cell accumulators, sample store, divider, median scan, output register.
`default_nettype none
module gca_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire                  i_cfg_idx,
    input  wire [2:0]            i_cfg_data,
    input  wire                  i_in_valid,
    input  gca_pkg::t_in_word    i_in_word,
    output gca_pkg::t_out_word   o_out_word,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    input  gca_pkg::t_dp_cmd     i_cmd,
    output gca_pkg::t_dp_stat    o_stat
);
    import gca_pkg::*;

    logic [2:0]              r_mode;
    logic                    r_prop;
    logic signed [TOT_W-1:0] r_total;
    logic signed [31:0]      r_ext;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_saw;
    logic signed [31:0]      r_mem [MAX_POINTS];
    logic signed [31:0]      r_rd_a, r_rd_b;
    logic [IDX_W-1:0]        r_i, r_j;
    logic [CNT_W-1:0]        r_lt, r_eq;
    logic                    r_pv;
    logic [TOT_W-1:0]        r_dvd;
    logic [CNT_W:0]          r_rem;
    logic                    r_neg;
    logic [DCNT_W-1:0]       r_dcnt;
    t_out_word               r_out;
    logic                    r_out_valid;

    logic               accept, push, take_ext;
    logic signed [31:0] v;
    logic [CNT_W:0]     rem_sh;
    logic               qbit;
    logic [CNT_W-1:0]   k;
    logic [CNT_W:0]     lt_eq;
    logic [TOT_W-1:0]   mag;
    logic [TOT_W-1:0]   quo;
    t_out_word          n_out;

    assign accept = i_in_valid && i_cmd.ready;
    assign v      = i_in_word.sample_value;
    assign push   = accept && i_in_word.has_sample && !i_in_word.sample_undefined
                    && (r_cnt < CNT_W'(MAX_POINTS));
    assign take_ext = (r_cnt == '0) || ((r_mode == MODE_MIN) ? (v < r_ext) : (v > r_ext));

    assign rem_sh = {r_rem[CNT_W-1:0], r_dvd[TOT_W-1]};
    assign qbit   = rem_sh >= {1'b0, r_cnt};
    assign k      = r_cnt >> 1;
    assign lt_eq  = {1'b0, r_lt} + {1'b0, r_eq};
    assign mag    = r_total[TOT_W-1] ? TOT_W'(-r_total) : TOT_W'(r_total);
    assign quo    = r_neg ? TOT_W'(-r_dvd) : r_dvd;

    always_comb begin
        n_out = '0;
        unique case (i_cmd.sel)
            SEL_UNDEF: n_out.result_undefined = 1'b1;
            SEL_SUM: begin
                if (r_total > TOT_W'(signed'(32'sh7fffffff)))
                    n_out.result_value = 32'sh7fffffff;
                else if (r_total < TOT_W'(signed'(32'sh80000000)))
                    n_out.result_value = 32'sh80000000;
                else
                    n_out.result_value = r_total[31:0];
            end
            SEL_EXT: n_out.result_value = r_ext;
            SEL_DIV: n_out.result_value = quo[31:0];
            SEL_MED: n_out.result_value = r_rd_a;
            default: n_out.result_undefined = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SUM;
            r_prop      <= 1'b0;
            r_total     <= '0;
            r_ext       <= '0;
            r_cnt       <= '0;
            r_saw       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_AGG_MODE) r_mode <= i_cfg_data;
                else r_prop <= i_cfg_data[0];
            end
            if (accept && i_in_word.has_sample && i_in_word.sample_undefined)
                r_saw <= 1'b1;
            if (push) begin
                if (take_ext) r_ext <= v;
                r_total <= r_total + TOT_W'(v);
                r_cnt   <= r_cnt + 1'b1;
            end
            r_pv <= i_cmd.med_issue;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_total <= '0;
                r_ext   <= '0;
                r_cnt   <= '0;
                r_saw   <= 1'b0;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_cnt[IDX_W-1:0]] <= v;
        r_rd_a <= r_mem[r_i];
        r_rd_b <= r_mem[r_j];
        if (i_cmd.out_load) r_out <= n_out;
        if (i_cmd.div_load) begin
            r_dvd  <= mag;
            r_rem  <= '0;
            r_neg  <= r_total[TOT_W-1];
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= qbit ? rem_sh - {1'b0, r_cnt} : rem_sh;
            r_dvd  <= {r_dvd[TOT_W-2:0], qbit};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.med_start || i_cmd.med_next) begin
            r_i  <= i_cmd.med_start ? '0 : r_i + 1'b1;
            r_j  <= '0;
            r_lt <= '0;
            r_eq <= '0;
        end else begin
            if (i_cmd.med_issue) r_j <= r_j + 1'b1;
            if (r_pv) begin
                if (r_rd_b < r_rd_a) r_lt <= r_lt + 1'b1;
                else if (r_rd_b == r_rd_a) r_eq <= r_eq + 1'b1;
            end
        end
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_stat             = '0;
        o_stat.cell_closed = accept && i_in_word.last_in_cell;
        o_stat.no_result   = (r_cnt == '0) || (r_prop && r_saw) || (r_mode > MODE_MIN);
        o_stat.mode        = r_mode;
        o_stat.div_last    = r_dcnt == DCNT_W'(DIV_STEPS - 1);
        o_stat.j_last      = {1'b0, r_j} == r_cnt - 1'b1;
        o_stat.med_hit     = ({1'b0, r_lt} <= {1'b0, k}) && ({1'b0, k} < lt_eq);
        o_stat.out_full    = r_out_valid;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS)) else $error("sample count over capacity");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid) else $error("result overwritten");
    a_quiet_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ready |-> !(i_cmd.div_step || i_cmd.med_issue || i_cmd.out_load))
        else $error("finalize work while taking words");
endmodule
`default_nettype wire

FILE: hw/rtl/gca_ctrl.sv
// Controller: sequences the end-of-cell finalize.
`default_nettype none
module gca_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  gca_pkg::t_dp_stat i_stat,
    output gca_pkg::t_dp_cmd  o_cmd
);
    import gca_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_FIN, S_DIV, S_MSCAN, S_MDRAIN, S_MCHECK, S_WRITE
    } t_state;

    t_state r_state;
    t_sel   r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_UNDEF;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_stat.cell_closed) r_state <= S_FIN;
                S_FIN: begin
                    if (i_stat.no_result) begin
                        r_sel <= SEL_UNDEF; r_state <= S_WRITE;
                    end else if (i_stat.mode == MODE_MEAN) begin
                        r_state <= S_DIV;
                    end else if (i_stat.mode == MODE_MEDIAN) begin
                        r_state <= S_MSCAN;
                    end else if (i_stat.mode == MODE_SUM) begin
                        r_sel <= SEL_SUM; r_state <= S_WRITE;
                    end else begin
                        r_sel <= SEL_EXT; r_state <= S_WRITE;
                    end
                end
                S_DIV: if (i_stat.div_last) begin
                    r_sel <= SEL_DIV; r_state <= S_WRITE;
                end
                S_MSCAN:  if (i_stat.j_last) r_state <= S_MDRAIN;
                S_MDRAIN: r_state <= S_MCHECK;
                S_MCHECK: begin
                    if (i_stat.med_hit) begin
                        r_sel <= SEL_MED; r_state <= S_WRITE;
                    end else begin
                        r_state <= S_MSCAN;
                    end
                end
                S_WRITE: if (!i_stat.out_full) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.sel       = r_sel;
        o_cmd.ready     = r_state == S_IDLE;
        o_cmd.div_load  = (r_state == S_FIN) && !i_stat.no_result && i_stat.mode == MODE_MEAN;
        o_cmd.med_start = (r_state == S_FIN) && !i_stat.no_result
                          && i_stat.mode == MODE_MEDIAN;
        o_cmd.div_step  = r_state == S_DIV;
        o_cmd.med_issue = r_state == S_MSCAN;
        o_cmd.med_next  = (r_state == S_MCHECK) && !i_stat.med_hit;
        o_cmd.out_load  = (r_state == S_WRITE) && !i_stat.out_full;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/grid_cell_aggregator.sv
// Top level of the grid cell aggregator.
`default_nettype none
// Takes one word per cycle while accumulating a cell; the word flagged
// last_in_cell closes it and the block then stalls its input while it
// finalizes. Sum, maximum, minimum and undefined results are loaded
// directly into the output register; mean runs a bit-serial divider;
// median compares every stored sample against each candidate through
// the two read ports of the sample store until the median is found. A
// finished result sits in the output register while the next cell
// streams in. At most 64 defined samples per cell are kept; further
// ones are ignored. The user must write configuration (index 0 agg_mode,
// index 1 undef_propagate) only while idle; the block does not enforce it.
module grid_cell_aggregator (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire                 i_cfg_idx,
    input  wire [2:0]           i_cfg_data,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  gca_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output gca_pkg::t_out_word  o_out_word
);
    import gca_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    gca_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gca_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // input word taken only while the controller is idle
    assign o_in_stall = !cmd.ready;
endmodule
`default_nettype wire
